>>> rtl/bdq_pkg.sv
// Shared types and codes for the bounded deque with search.
package bdq_pkg;

  localparam int unsigned CountOutW = 5;

  typedef enum logic [2:0] {
    K_PUSH_FRONT = 3'd0,
    K_PUSH_BACK  = 3'd1,
    K_POP_FRONT  = 3'd2,
    K_POP_BACK   = 3'd3,
    K_PEEK_FRONT = 3'd4,
    K_PEEK_BACK  = 3'd5,
    K_CONTAINS   = 3'd6,
    K_REMOVE     = 3'd7
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_FULL    = 2'd2,
    ST_MISSING = 2'd3
  } status_e;

  // What every cell does with its entry in the cycle an item completes.
  typedef enum logic [2:0] {
    CELL_HOLD,  // keep the entry
    CELL_SHR,   // take the left neighbour's entry, the front cell takes the operand
    CELL_PUT,   // the cell at the back position takes the operand
    CELL_SHL,   // take the right neighbour's entry
    CELL_DROP   // take the right neighbour's entry from the first match onwards
  } cell_op_e;

  typedef struct packed {
    cell_op_e    op;
    logic [31:0] operand;
  } cell_ctl_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

endpackage

>>> rtl/bdq_cell.sv
// One storage cell of the deque chain: entry register, compare and neighbour hand-off.
module bdq_cell #(
  parameter int unsigned Idx    = 0,
  parameter int unsigned CountW = 5
) (
  input  logic              clk_i,
  input  bdq_pkg::cell_ctl_t ctl_i,
  input  logic [CountW-1:0] count_i,
  input  logic [CountW-1:0] last_i,
  input  logic [31:0]       left_i,
  input  logic [31:0]       right_i,
  input  logic              hit_i,
  output logic              hit_o,
  input  logic [31:0]       rd_i,
  output logic [31:0]       rd_o,
  output logic [31:0]       value_o
);

  localparam logic [CountW-1:0] MyIdx = CountW'(Idx);

  logic [31:0] value_q, value_d;
  logic        occupied, match;

  assign occupied = MyIdx < count_i;
  assign match    = occupied && (value_q == ctl_i.operand);
  // The hit flag means a match at this cell or at any cell nearer the front.
  assign hit_o    = hit_i | match;
  assign rd_o     = (MyIdx == last_i) ? value_q : rd_i;
  assign value_o  = value_q;

  always_comb begin
    value_d = value_q;
    unique case (ctl_i.op)
      bdq_pkg::CELL_HOLD: value_d = value_q;
      bdq_pkg::CELL_SHR:  value_d = (Idx == 0) ? ctl_i.operand : left_i;
      bdq_pkg::CELL_PUT:  value_d = (MyIdx == count_i) ? ctl_i.operand : value_q;
      bdq_pkg::CELL_SHL:  value_d = right_i;
      bdq_pkg::CELL_DROP: value_d = hit_o ? right_i : value_q;
      default:            value_d = value_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

endmodule

>>> rtl/bounded_deque_with_search_core.sv
// Top level of the bounded deque with search: control, count and the chain of cells.
//
//   channel | handshake               | fields
//   --------+-------------------------+-----------------------------------------------
//   input   | in_valid_i / in_stall_o | kind_i, operand_value_i
//   output  | out_valid_o/out_stall_i | read_value_o, found_o, status_o, entry_count_o
//
// Every item is captured in the idle state; in the execute state all cells compare,
// shift and update together while the result is written to the output register.
// The execute cycle is set by the ripple of the first-match and back-read chains
// through the row of DEPTH cells.
// A new item is taken while a finished result still waits in the output register;
// the execute cycle then holds until that register is free.
// Reset clears the count and the control; the entries themselves are not cleared,
// since only the first count entries are ever read.
module bounded_deque_with_search_core #(
  parameter int unsigned DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  kind_i,
  input  logic [31:0] operand_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] read_value_o,
  output logic        found_o,
  output logic [1:0]  status_o,
  output logic [4:0]  entry_count_o
);

  localparam int unsigned CountW = $clog2(DEPTH + 1);
  localparam logic [CountW-1:0] Full = CountW'(DEPTH);
  localparam logic [CountW-1:0] One  = CountW'(1);

  bdq_pkg::state_e state_q, state_d;

  // Captured item; payload only, so no reset.
  bdq_pkg::kind_e kind_q;
  logic [31:0]    operand_q;

  logic [CountW-1:0] count_q, count_d, last_idx;

  logic                  out_valid_q;
  logic [31:0]           read_value_q, read_value_d;
  logic                  found_q, found_d;
  bdq_pkg::status_e      status_q, status_d;

  logic                  accept, done;
  bdq_pkg::cell_op_e     op_d;
  bdq_pkg::cell_ctl_t    ctl;

  logic [31:0] cell_val [DEPTH];
  logic [DEPTH:0] hit;
  logic [31:0] rd_chain [DEPTH+1];
  logic empty, full;

  assign accept = in_valid_i && !in_stall_o;
  // The execute cycle finishes once the output register is free or being emptied.
  assign done   = (state_q == bdq_pkg::S_EXEC) && (!out_valid_q || !out_stall_i);

  assign empty    = (count_q == '0);
  assign full     = (count_q == Full);
  assign last_idx = count_q - One;

  // Next state and the outcome of the captured item.
  always_comb begin
    state_d      = state_q;
    in_stall_o   = 1'b1;
    count_d      = count_q;
    op_d         = bdq_pkg::CELL_HOLD;
    read_value_d = '0;
    found_d      = 1'b0;
    status_d     = bdq_pkg::ST_OK;

    unique case (kind_q)
      bdq_pkg::K_PUSH_FRONT, bdq_pkg::K_PUSH_BACK: begin
        if (full) begin
          status_d = bdq_pkg::ST_FULL;
        end else begin
          op_d    = (kind_q == bdq_pkg::K_PUSH_FRONT) ? bdq_pkg::CELL_SHR
                                                      : bdq_pkg::CELL_PUT;
          count_d = count_q + One;
        end
      end
      bdq_pkg::K_POP_FRONT, bdq_pkg::K_PEEK_FRONT: begin
        if (empty) begin
          status_d = bdq_pkg::ST_EMPTY;
        end else begin
          read_value_d = cell_val[0];
          if (kind_q == bdq_pkg::K_POP_FRONT) begin
            op_d    = bdq_pkg::CELL_SHL;
            count_d = count_q - One;
          end
        end
      end
      bdq_pkg::K_POP_BACK, bdq_pkg::K_PEEK_BACK: begin
        if (empty) begin
          status_d = bdq_pkg::ST_EMPTY;
        end else begin
          read_value_d = rd_chain[0];
          if (kind_q == bdq_pkg::K_POP_BACK) begin
            count_d = count_q - One;
          end
        end
      end
      bdq_pkg::K_CONTAINS, bdq_pkg::K_REMOVE: begin
        if (empty) begin
          status_d = bdq_pkg::ST_EMPTY;
        end else if (hit[DEPTH]) begin
          found_d = 1'b1;
          if (kind_q == bdq_pkg::K_REMOVE) begin
            op_d    = bdq_pkg::CELL_DROP;
            count_d = count_q - One;
          end
        end else if (kind_q == bdq_pkg::K_REMOVE) begin
          status_d = bdq_pkg::ST_MISSING;
        end
      end
      default: status_d = bdq_pkg::ST_OK;
    endcase

    unique case (state_q)
      bdq_pkg::S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          state_d = bdq_pkg::S_EXEC;
        end
      end
      bdq_pkg::S_EXEC: begin
        if (done) begin
          state_d = bdq_pkg::S_IDLE;
        end
      end
      default: state_d = bdq_pkg::S_IDLE;
    endcase
  end

  // Cells only act in the cycle the result is committed.
  assign ctl.op      = done ? op_d : bdq_pkg::CELL_HOLD;
  assign ctl.operand = operand_q;

  assign hit[0]          = 1'b0;
  assign rd_chain[DEPTH] = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [31:0] left_val, right_val;
    if (i == 0) begin : g_first
      assign left_val = operand_q;
    end else begin : g_mid_l
      assign left_val = cell_val[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_val = cell_val[i];
    end else begin : g_mid_r
      assign right_val = cell_val[i+1];
    end

    bdq_cell #(
      .Idx    (i),
      .CountW (CountW)
    ) u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl),
      .count_i (count_q),
      .last_i  (last_idx),
      .left_i  (left_val),
      .right_i (right_val),
      .hit_i   (hit[i]),
      .hit_o   (hit[i+1]),
      .rd_i    (rd_chain[i+1]),
      .rd_o    (rd_chain[i]),
      .value_o (cell_val[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bdq_pkg::S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (done) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q    <= bdq_pkg::kind_e'(kind_i);
      operand_q <= operand_value_i;
    end
    if (done) begin
      read_value_q <= read_value_d;
      found_q      <= found_d;
      status_q     <= status_d;
    end
  end

  logic [CountW+4:0] count_wide;
  assign count_wide = {5'b0, count_q};

  assign out_valid_o   = out_valid_q;
  assign read_value_o  = read_value_q;
  assign found_o       = found_q;
  assign status_o      = status_q;
  assign entry_count_o = count_wide[bdq_pkg::CountOutW-1:0];

  // The count never passes the capacity.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= Full)
    else $error("deque count exceeds capacity");

  // An accepted item always moves the block to its execute cycle.
  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == bdq_pkg::S_EXEC)
    else $error("accepted item did not start execution");

  // A finished item always shows up as a valid result.
  a_done_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |=> out_valid_q)
    else $error("completed item produced no result");

  // A push refused as full leaves the count at capacity.
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done && status_d == bdq_pkg::ST_FULL |=> count_q == Full)
    else $error("full status with count below capacity");

  // A found flag only comes from a non-empty deque.
  a_found_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done && found_d |-> !empty)
    else $error("match reported on an empty deque");

endmodule

>>> tb/sv/bounded_deque_with_search_core_test.sv
// Self-checking testbench for the bounded deque with search core.
module bounded_deque_with_search_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Depth = 16;
  // This limit leaves ample room above the slowest correct run.
  localparam int CycleLimit = 250000;
  localparam int ItemsPerPhase = 567;

  // One result item as it leaves the block.
  typedef struct packed {
    logic [31:0]      read_value;
    logic             found;
    bdq_pkg::status_e status;
    logic [4:0]       entry_count;
  } outcome_t;

  // One row of the directed table. A row may repeat its item several times. Where
  // typed is set, the expected result is written out in the row itself; otherwise
  // the deque predictor supplies it.
  typedef struct packed {
    bdq_pkg::kind_e kind;
    logic [31:0]    operand;
    logic [4:0]     reps;
    logic           typed;
    outcome_t       want;
  } step_t;

  localparam int Rows = 19;
  localparam step_t DirectedSteps [Rows] = '{
    // Every operation other than a push, on an empty deque straight after reset.
    '{bdq_pkg::K_POP_FRONT,  32'h0000_0000, 5'd1,  1'b1,
      '{32'h0000_0000, 1'b0, bdq_pkg::ST_EMPTY,   5'd0}},
    '{bdq_pkg::K_POP_BACK,   32'h0000_0000, 5'd1,  1'b1,
      '{32'h0000_0000, 1'b0, bdq_pkg::ST_EMPTY,   5'd0}},
    '{bdq_pkg::K_PEEK_FRONT, 32'h0000_0000, 5'd1,  1'b1,
      '{32'h0000_0000, 1'b0, bdq_pkg::ST_EMPTY,   5'd0}},
    '{bdq_pkg::K_PEEK_BACK,  32'h0000_0000, 5'd1,  1'b1,
      '{32'h0000_0000, 1'b0, bdq_pkg::ST_EMPTY,   5'd0}},
    '{bdq_pkg::K_CONTAINS,   32'h0000_0000, 5'd1,  1'b1,
      '{32'h0000_0000, 1'b0, bdq_pkg::ST_EMPTY,   5'd0}},
    '{bdq_pkg::K_REMOVE,     32'h0000_0000, 5'd1,  1'b1,
      '{32'h0000_0000, 1'b0, bdq_pkg::ST_EMPTY,   5'd0}},
    // The two extreme values, one at each end.
    '{bdq_pkg::K_PUSH_BACK,  32'h7FFF_FFFF, 5'd1,  1'b1,
      '{32'h0000_0000, 1'b0, bdq_pkg::ST_OK,      5'd1}},
    '{bdq_pkg::K_PUSH_FRONT, 32'h8000_0000, 5'd1,  1'b1,
      '{32'h0000_0000, 1'b0, bdq_pkg::ST_OK,      5'd2}},
    '{bdq_pkg::K_PEEK_FRONT, 32'h0000_0000, 5'd1,  1'b1,
      '{32'h8000_0000, 1'b0, bdq_pkg::ST_OK,      5'd2}},
    '{bdq_pkg::K_PEEK_BACK,  32'h0000_0000, 5'd1,  1'b1,
      '{32'h7FFF_FFFF, 1'b0, bdq_pkg::ST_OK,      5'd2}},
    // An absent value is no error for a search, but it is for a removal.
    '{bdq_pkg::K_CONTAINS,   32'h0000_0005, 5'd1,  1'b1,
      '{32'h0000_0000, 1'b0, bdq_pkg::ST_OK,      5'd2}},
    '{bdq_pkg::K_REMOVE,     32'h0000_0005, 5'd1,  1'b1,
      '{32'h0000_0000, 1'b0, bdq_pkg::ST_MISSING, 5'd2}},
    '{bdq_pkg::K_CONTAINS,   32'h7FFF_FFFF, 5'd1,  1'b0, '0},
    // Fill up with duplicates, then push into a full deque at both ends.
    '{bdq_pkg::K_PUSH_BACK,  32'hFFFF_FFFF, 5'd14, 1'b0, '0},
    '{bdq_pkg::K_PUSH_FRONT, 32'h0000_0001, 5'd1,  1'b1,
      '{32'h0000_0000, 1'b0, bdq_pkg::ST_FULL,    5'd16}},
    '{bdq_pkg::K_PUSH_BACK,  32'h0000_0002, 5'd1,  1'b1,
      '{32'h0000_0000, 1'b0, bdq_pkg::ST_FULL,    5'd16}},
    // Only the frontmost duplicate goes, and the later entries close the gap.
    '{bdq_pkg::K_REMOVE,     32'hFFFF_FFFF, 5'd1,  1'b0, '0},
    '{bdq_pkg::K_POP_FRONT,  32'h0000_0000, 5'd1,  1'b0, '0},
    '{bdq_pkg::K_POP_BACK,   32'h0000_0000, 5'd1,  1'b0, '0}
  };

  logic           clk_i = 1'b0;
  logic           rst_n = 1'b0;
  logic           in_valid = 1'b0;
  logic           in_stall;
  bdq_pkg::kind_e kind = bdq_pkg::K_PUSH_FRONT;
  logic [31:0]    operand = '0;
  logic           out_valid;
  logic           out_stall = 1'b0;
  logic [31:0]    read_value;
  logic           found;
  logic [1:0]     status;
  logic [4:0]     entry_count;

  // Idling chances in percent per cycle, set per phase by the stimulus process.
  int unsigned tx_idle_pct = 0;
  int unsigned rx_stall_pct = 0;

  // The predictor's copy of the deque, front at index 0, and the results still owed.
  logic [31:0] model_entries[$];
  outcome_t    awaited_results[$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;

  bounded_deque_with_search_core #(
    .DEPTH(Depth)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .kind_i         (kind),
    .operand_value_i(operand),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .read_value_o   (read_value),
    .found_o        (found),
    .status_o       (status),
    .entry_count_o  (entry_count)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Applies one operation to the predictor's deque and returns the result it owes.
  function automatic outcome_t deque_apply(bdq_pkg::kind_e op, logic [31:0] value);
    outcome_t res;
    int       hit;
    res = '0;
    res.status = bdq_pkg::ST_OK;
    hit = -1;
    if (op == bdq_pkg::K_PUSH_FRONT || op == bdq_pkg::K_PUSH_BACK) begin
      if (model_entries.size() >= Depth) begin
        res.status = bdq_pkg::ST_FULL;
      end else if (op == bdq_pkg::K_PUSH_FRONT) begin
        model_entries.push_front(value);
      end else begin
        model_entries.push_back(value);
      end
    end else if (model_entries.size() == 0) begin
      res.status = bdq_pkg::ST_EMPTY;
    end else begin
      case (op)
        bdq_pkg::K_POP_FRONT:  res.read_value = model_entries.pop_front();
        bdq_pkg::K_POP_BACK:   res.read_value = model_entries.pop_back();
        bdq_pkg::K_PEEK_FRONT: res.read_value = model_entries[0];
        bdq_pkg::K_PEEK_BACK:  res.read_value = model_entries[model_entries.size() - 1];
        default: begin
          // Contains and remove both look for the frontmost match.
          for (int i = 0; i < model_entries.size(); i++) begin
            if (hit < 0 && model_entries[i] == value) hit = i;
          end
          if (hit >= 0) begin
            res.found = 1'b1;
            if (op == bdq_pkg::K_REMOVE) model_entries.delete(hit);
          end else if (op == bdq_pkg::K_REMOVE) begin
            res.status = bdq_pkg::ST_MISSING;
          end
        end
      endcase
    end
    res.entry_count = 5'(model_entries.size());
    return res;
  endfunction

  // Offers one item, possibly after some idle cycles, and waits until the block takes
  // it. It is called just after a rising edge and leaves valid high on return, so
  // back-to-back items never lower and raise valid within one time step.
  task automatic issue_item(input bdq_pkg::kind_e op, input logic [31:0] value,
                            input logic typed, input outcome_t want);
    outcome_t predicted;
    if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      kind <= bdq_pkg::kind_e'($urandom_range(0, 7));
      operand <= $urandom;
      do @(posedge clk_i); while ($urandom_range(0, 99) < tx_idle_pct);
    end
    in_valid <= 1'b1;
    kind <= op;
    operand <= value;
    // Values sampled right after the edge are those from before it.
    do @(posedge clk_i); while (in_stall);
    predicted = deque_apply(op, value);
    awaited_results.push_back(typed ? want : predicted);
  endtask

  // Lowers valid and holds the sender back until every owed result has arrived.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (awaited_results.size() != 0);
  endtask

  // The receiver stalls at random at the rate of the current phase.
  always @(posedge clk_i) begin
    out_stall <= (rx_stall_pct != 0) && ($urandom_range(0, 99) < rx_stall_pct);
  end

  // Each accepted result is matched against the oldest expectation.
  always @(posedge clk_i) begin
    outcome_t got;
    outcome_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{read_value: read_value, found: found, status: bdq_pkg::status_e'(status),
              entry_count: entry_count};
      if (awaited_results.size() == 0) begin
        if (mismatches < 10) begin
          $display("unexpected result: read %0d found %0b status %0d count %0d",
                   $signed(got.read_value), got.found, got.status, got.entry_count);
        end
        mismatches++;
      end else begin
        want = awaited_results.pop_front();
        if (got !== want) begin
          if (mismatches < 10) begin
            $display("mismatch at %0t: read %0d/%0d found %0b/%0b status %0d/%0d count %0d/%0d",
                     $realtime, $signed(want.read_value), $signed(got.read_value),
                     want.found, got.found, want.status, got.status,
                     want.entry_count, got.entry_count);
          end
          mismatches++;
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int unsigned    tx_plan[3];
    int unsigned    rx_plan[3];
    int unsigned    push_pct;
    bdq_pkg::kind_e op;
    logic [31:0]    value;
    // Receiver-heavy idling first, then sender-heavy, then none at all.
    tx_plan = '{36, 67, 0};
    rx_plan = '{67, 36, 0};
    push_pct = 50;

    repeat (2) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // Directed part: walked row by row without idling.
    for (int r = 0; r < Rows; r++) begin
      for (int n = 0; n < DirectedSteps[r].reps; n++) begin
        issue_item(DirectedSteps[r].kind, DirectedSteps[r].operand, DirectedSteps[r].typed,
                   DirectedSteps[r].want);
      end
    end
    drain_results();

    // Random part. The share of pushes wanders from stretch to stretch so that the
    // deque keeps swinging between empty and full. Operands mostly come from values
    // already held or from a small pool, so searches and removals often hit and
    // duplicates are common; the rest are full-width random words.
    for (int phase = 0; phase < 3; phase++) begin
      tx_idle_pct = tx_plan[phase];
      rx_stall_pct = rx_plan[phase];
      for (int n = 0; n < ItemsPerPhase; n++) begin
        if (n % 48 == 0) push_pct = $urandom_range(10, 90);
        if ($urandom_range(0, 99) < push_pct) begin
          op = $urandom_range(0, 1) ? bdq_pkg::K_PUSH_BACK : bdq_pkg::K_PUSH_FRONT;
        end else begin
          op = bdq_pkg::kind_e'($urandom_range(2, 7));
        end
        if (model_entries.size() != 0 && $urandom_range(0, 1) == 1) begin
          value = model_entries[$urandom_range(0, model_entries.size() - 1)];
        end else if ($urandom_range(0, 3) != 0) begin
          value = 32'($urandom_range(0, 15)) - 32'd8;
        end else begin
          value = $urandom;
        end
        issue_item(op, value, 1'b0, '0);
      end
      // The sender waits here for every owed result before the next phase begins.
      drain_results();
    end

    // Wait for any stray result beyond the last one expected.
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/bdq_pkg.sv
rtl/bdq_cell.sv
rtl/bounded_deque_with_search_core.sv
tb/sv/bounded_deque_with_search_core_test.sv
